// File: rtl/core/tms_pkg.sv
// package for the transform matrix stack: commands, status codes, types
`default_nettype none
package tms_pkg;
  localparam int unsigned DIM = 4;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_CAT  = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EMIT, S_RD_TOP, S_RD_NXT, S_MAC, S_WR, S_REPLY
  } state_t;

  typedef logic signed [31:0] word_t;
  typedef logic [1:0] row_t;
endpackage
`default_nettype wire

// File: rtl/core/tms_lane.sv
// one multiply-accumulate lane: q16.16 product, floor shift, sum saturated on output
`default_nettype none
module tms_lane (
  input  wire logic         clk,
  input  wire logic         clr,
  input  wire logic         en,
  input  wire tms_pkg::word_t a,
  input  wire tms_pkg::word_t b,
  output tms_pkg::word_t    result
);
  import tms_pkg::*;

  logic signed [63:0] prod;
  logic signed [47:0] prod_sh;

  always_comb begin
    prod     = 64'(a) * 64'(b);
    prod_sh  = prod[63:16];
  end

  // product register then accumulate
  logic signed [47:0] prod_q;
  logic               en_q;
  logic signed [49:0] acc;
  always_ff @(posedge clk) begin
    prod_q <= prod_sh;
    en_q   <= en;
    if (clr) acc <= '0;
    else if (en_q) acc <= acc + 50'(prod_q);
  end

  always_comb begin
    if (acc > 50'sd2147483647) result = 32'sh7fffffff;
    else if (acc < -50'sd2147483648) result = 32'sh80000000;
    else result = acc[31:0];
  end
endmodule
`default_nettype wire

// File: rtl/core/transform_matrix_stack.sv
// top level of the transform matrix stack
// Stack of 4x4 Q16.16 matrices held in a memory with one write and one read port, one 4-word row per address.
// Push rows 0..2 are taken with no reply; a push commit writes the four rows in S_WR and
// then offers its reply from S_REPLY. Error replies and refused pushes go straight from
// S_IDLE to S_REPLY.
// Pop and read-top return four row transactions; each row is read and registered before it
// is offered, and the next row is read only once the current one has been taken.
// Concatenate reads both matrices (8 row reads), then four lanes, one per output column,
// compute each output row in S_MAC, multiply-accumulate and then drain through the lane
// registers, and S_WR writes it back before the next row; the reply comes from S_REPLY.
`default_nettype none
module transform_matrix_stack #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [1:0]  row_index,
  input  wire logic [31:0] elem_a,
  input  wire logic [31:0] elem_b,
  input  wire logic [31:0] elem_c,
  input  wire logic [31:0] elem_d,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [1:0]       out_row,
  output logic [31:0]      out_a,
  output logic [31:0]      out_b,
  output logic [31:0]      out_c,
  output logic [31:0]      out_d,
  output logic             last
);
  import tms_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int MW = AW + 2;

  state_t state, state_next;
  logic [CW-1:0] count;
  logic [1:0]    step;
  logic [2:0]    cyc;
  logic          is_pop;

  logic [127:0] mem [STACK_DEPTH*4];
  logic [127:0] stage [4];
  logic [127:0] rd_data;
  logic [127:0] top_m [4];
  logic [127:0] nxt_m [4];
  logic         mem_we;
  logic [MW-1:0] mem_waddr, mem_raddr;
  logic [127:0] mem_wdata;

  logic [AW-1:0] top_idx, nxt_idx;
  assign top_idx = AW'(count - CW'(1));
  assign nxt_idx = AW'(count - CW'(2));

  logic accept;
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign accept = in_valid && in_ready;

  // read pipeline: rd_step tracks which row lands in rd_data
  logic       rd_v;
  logic       rd_issue;
  logic [1:0] rd_step;
  logic       rd_nxt;
  assign rd_issue = (state == S_RD_TOP) || (state == S_RD_NXT) ||
                    ((state == S_EMIT) && !out_valid && !rd_v);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[mem_raddr];
  end

  // lanes
  word_t lane_a [4];
  word_t lane_b [4];
  word_t lane_r [4];
  logic  lane_clr, lane_en;
  for (genvar g = 0; g < 4; g++) begin : g_lane
    tms_lane u_lane (.clk(clk), .clr(lane_clr), .en(lane_en),
      .a(lane_a[g]), .b(lane_b[g]), .result(lane_r[g]));
  end

  logic [127:0] top_row;
  assign top_row = top_m[step];
  for (genvar g = 0; g < 4; g++) begin : g_sel
    assign lane_a[g] = top_row[127-32*cyc[1:0] -: 32];
    assign lane_b[g] = nxt_m[cyc[1:0]][127-32*g -: 32];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) begin
        unique case (cmd_t'(command))
          CMD_PUSH: if (row_index == 2'd3) state_next = (count >= CW'(STACK_DEPTH)) ?
                                                         S_REPLY : S_WR;
          CMD_POP, CMD_READ: state_next = (count == '0) ? S_REPLY : S_EMIT;
          CMD_CAT: state_next = (count < CW'(2)) ? S_REPLY : S_RD_TOP;
        endcase
      end
      S_EMIT:   if (out_valid && out_ready && last) state_next = S_IDLE;
      S_RD_TOP: if (step == 2'd3) state_next = S_RD_NXT;
      S_RD_NXT: if (step == 2'd3) state_next = S_MAC;
      S_MAC:    if (cyc == 3'd6) state_next = S_WR;
      S_WR: begin
        if (!is_pop) state_next = (step == 2'd3) ? S_REPLY : S_MAC;
        else if (step == 2'd3) state_next = S_REPLY;
      end
      S_REPLY:  if (out_valid && out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {top_idx, 2'd0};
    mem_wdata = stage[step];
    mem_raddr = {top_idx, step};
    lane_clr  = 1'b0;
    lane_en   = (state == S_MAC) && (cyc < 3'd4);
    unique case (state)
      S_WR: begin
        mem_we = 1'b1;
        if (is_pop) begin
          mem_waddr = {top_idx, step};
          mem_wdata = stage[step];
        end else begin
          mem_waddr = {nxt_idx, step};
          mem_wdata = {lane_r[0], lane_r[1], lane_r[2], lane_r[3]};
        end
      end
      S_RD_NXT: mem_raddr = {nxt_idx, step};
      S_MAC:    lane_clr = (cyc == 3'd0);
      default: ;
    endcase
  end

  // is_pop doubles as the push commit flag in S_WR
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; out_valid <= 1'b0; step <= '0;
      cyc <= '0; rd_v <= 1'b0; is_pop <= 1'b0;
    end else begin
      state <= state_next;
      rd_v <= rd_issue;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) begin
          step <= '0; cyc <= '0;
          status <= ST_OK; out_row <= '0; last <= 1'b1;
          out_a <= '0; out_b <= '0; out_c <= '0; out_d <= '0;
          if (command == CMD_PUSH) begin
            stage[row_index] <= {elem_a, elem_b, elem_c, elem_d};
            if (row_index == 2'd3) begin
              is_pop <= 1'b1;
              if (count >= CW'(STACK_DEPTH)) status <= ST_OVER;
              else count <= count + CW'(1);
            end
          end else if (command == CMD_CAT) begin
            is_pop <= 1'b0;
            if (count < CW'(2)) status <= ST_EMPTY;
          end else begin
            if (count == '0) status <= ST_EMPTY;
            is_pop <= (command == CMD_POP);
          end
        end
        S_EMIT: begin
          // one row read issued per transaction, held until taken
          if (rd_v) begin
            {out_a, out_b, out_c, out_d} <= rd_data;
            out_row <= step; last <= (step == 2'd3); status <= ST_OK;
            out_valid <= 1'b1;
          end else if (out_valid && out_ready) begin
            if (!last) step <= step + 2'd1;
            else if (is_pop) count <= count - CW'(1);
          end
        end
        S_RD_TOP, S_RD_NXT: step <= step + 2'd1;
        S_MAC: cyc <= cyc + 3'd1;
        S_WR: begin
          if (!is_pop) begin
            if (step == 2'd3) begin
              count <= count - CW'(1);
            end else begin
              step <= step + 2'd1; cyc <= '0;
            end
          end else step <= step + 2'd1;
        end
        S_REPLY: if (!out_valid) out_valid <= 1'b1;
        default: ;
      endcase
      // operand rows are taken from the registered read data into top_m or nxt_m
      if (rd_v && state != S_EMIT) begin
        if (rd_nxt) nxt_m[rd_step] <= rd_data;
        else top_m[rd_step] <= rd_data;
      end
    end
  end

  // row index latched alongside the read for the fill sequences
  always_ff @(posedge clk) begin
    rd_step <= step;
    rd_nxt  <= (state == S_RD_NXT);
  end
endmodule
`default_nettype wire
